// ----- src/montgomery_field_multiplier_assert.svh -----
// Assertion macros for the Montgomery field multiplier.
`ifndef MONTGOMERY_FIELD_MULTIPLIER_ASSERT_SVH
`define MONTGOMERY_FIELD_MULTIPLIER_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define MFM_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mfm assertion failed");

// Clocked check, active during reset too.
`define MFM_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mfm assertion failed");

`endif

// ----- src/mfm_pkg.sv -----
// Package: constants, types and codes of the Montgomery field multiplier.
package mfm_pkg;

    localparam int LIMB_COUNT     = 4;
    localparam int LIMB_W         = 64;
    localparam int STEPS_PER_ITER = 9;
    localparam int CELL_COUNT     = LIMB_COUNT * STEPS_PER_ITER;

    localparam logic [LIMB_COUNT-1:0][LIMB_W-1:0] MOD_Q = '{
        64'h30644e72e131a029, 64'hb85045b68181585d,
        64'h97816a916871ca8d, 64'h3c208c16d87cfd47
    };
    localparam logic [LIMB_COUNT-1:0][LIMB_W-1:0] R_SQUARED = '{
        64'h06d89f71cab8351f, 64'h47ab1eff0a417ff6,
        64'hb5e71911d44501fb, 64'hf32cfc5b538afa89
    };
    localparam logic [LIMB_W-1:0] NEG_Q_INV = 64'h87d20782e4866389;

    typedef enum logic [1:0] {
        KIND_FULL    = 2'd0,
        KIND_WORD    = 2'd1,
        KIND_TO_MONT = 2'd2
    } kind_t;

    // Operation of one cell.
    typedef enum logic [1:0] {
        OP_MAC_AB = 2'd0,  // t[j] += a[j] * b[i] + c
        OP_MQINV  = 2'd1,  // m = t[0] * -q^-1 mod 2^64
        OP_RED0   = 2'd2,  // c = hi(t[0] + m * q[0])
        OP_MAC_Q  = 2'd3   // t[j-1] = t[j] + m * q[j] + c
    } op_t;

    // Working state handed from cell to cell.
    typedef struct packed {
        logic [LIMB_COUNT-1:0][LIMB_W-1:0] a;
        logic [LIMB_COUNT-1:0][LIMB_W-1:0] b;
        logic [LIMB_COUNT+1:0][LIMB_W-1:0] t;
        logic [LIMB_W-1:0]                 c;
        logic [LIMB_W-1:0]                 m;
    } st_t;

endpackage

// ----- src/mfm_cell.sv -----
// One multiply-accumulate cell of the Montgomery chain (two stages).
module mfm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  mfm_pkg::op_t        op,
    input  logic [1:0]          iter,
    input  logic [1:0]          idx,
    input  logic                in_valid,
    input  mfm_pkg::st_t        in_st,
    output logic                out_valid,
    output mfm_pkg::st_t        out_st
);

    logic [63:0]       x;
    logic [63:0]       y;
    logic [3:0][63:0]  pp_next;
    logic [3:0][63:0]  pp_reg;
    mfm_pkg::st_t      st1_reg;
    mfm_pkg::st_t      st2_next;
    mfm_pkg::st_t      st2_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic [127:0]      prod;
    logic [127:0]      sum;
    logic [64:0]       top_sum;
    logic [1:0]        idx_m1;

    // Stage 1: operand select and 32x32 partial products.
    always_comb begin
        case (op)
            mfm_pkg::OP_MAC_AB: begin
                x = in_st.a[idx];
                y = in_st.b[iter];
            end
            mfm_pkg::OP_MQINV: begin
                x = in_st.t[0];
                y = mfm_pkg::NEG_Q_INV;
            end
            mfm_pkg::OP_RED0: begin
                x = in_st.m;
                y = mfm_pkg::MOD_Q[0];
            end
            default: begin
                x = in_st.m;
                y = mfm_pkg::MOD_Q[idx];
            end
        endcase
        pp_next[0] = x[31:0]  * y[31:0];
        pp_next[1] = x[31:0]  * y[63:32];
        pp_next[2] = x[63:32] * y[31:0];
        pp_next[3] = x[63:32] * y[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg  <= pp_next;
            st1_reg <= in_st;
            st2_reg <= st2_next;
        end
    end

    // Stage 2: combine partials, accumulate, update state.
    always_comb begin
        prod = {64'd0, pp_reg[0]} + {32'd0, pp_reg[1], 32'd0}
             + {32'd0, pp_reg[2], 32'd0} + {pp_reg[3], 64'd0};
        st2_next = st1_reg;
        idx_m1   = idx - 2'd1;
        sum      = '0;
        top_sum  = '0;
        case (op)
            mfm_pkg::OP_MAC_AB: begin
                sum = prod + {64'd0, st1_reg.t[{1'b0, idx}]}
                    + ((idx == 2'd0) ? 128'd0 : {64'd0, st1_reg.c});
                st2_next.t[{1'b0, idx}] = sum[63:0];
                st2_next.c              = sum[127:64];
                if (idx == 2'd3) begin
                    top_sum = {1'b0, st1_reg.t[4]} + {1'b0, sum[127:64]};
                    st2_next.t[4] = top_sum[63:0];
                    st2_next.t[5] = {63'd0, top_sum[64]};
                end
            end
            mfm_pkg::OP_MQINV: begin
                st2_next.m = prod[63:0];
            end
            mfm_pkg::OP_RED0: begin
                sum = prod + {64'd0, st1_reg.t[0]};
                st2_next.c = sum[127:64];
            end
            default: begin
                sum = prod + {64'd0, st1_reg.t[{1'b0, idx}]} + {64'd0, st1_reg.c};
                st2_next.t[{1'b0, idx_m1}] = sum[63:0];
                st2_next.c                 = sum[127:64];
                if (idx == 2'd3) begin
                    top_sum = {1'b0, st1_reg.t[4]} + {1'b0, sum[127:64]};
                    st2_next.t[3] = top_sum[63:0];
                    st2_next.t[4] = st1_reg.t[5] + {63'd0, top_sum[64]};
                end
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign out_st    = st2_reg;

endmodule

// ----- src/montgomery_field_multiplier.sv -----
// Montgomery multiplier over the BN254 base field: 36-cell pipelined chain.
//
// Input channel s_*: kind plus operands a and b as four 64-bit limbs each,
// limb 0 least significant. Kind 0 (and 3) multiplies a*b, kind 1 a*b_limb0,
// kind 2 converts a to Montgomery form (b = R^2 mod q).
// Result channel m_*: r = a*b*2^-256 mod q, one item per input item, in order.
// Pipeline: 36 cells of two stages each, plus the final subtract stage,
// lie between acceptance and m_valid.
// Throughput: one item per cycle while not stalled; each cell holds one
// 64x64 multiply built from four 32x32 products, and the whole chain advances together.
// Stall: while m_valid is high and m_ready low, the chain and s_ready hold;
// nothing is lost or repeated. s_ready is high whenever the output register
// is empty or being taken.
// Reset: aresetn (synchronous, active low) clears all valid bits; items in
// flight are dropped.
`include "montgomery_field_multiplier_assert.svh"

module montgomery_field_multiplier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_a_limb0,
    input  logic [63:0] s_a_limb1,
    input  logic [63:0] s_a_limb2,
    input  logic [63:0] s_a_limb3,
    input  logic [63:0] s_b_limb0,
    input  logic [63:0] s_b_limb1,
    input  logic [63:0] s_b_limb2,
    input  logic [63:0] s_b_limb3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_r_limb0,
    output logic [63:0] m_r_limb1,
    output logic [63:0] m_r_limb2,
    output logic [63:0] m_r_limb3
);

    logic                                 en;
    mfm_pkg::st_t                         st_in;
    logic         [mfm_pkg::CELL_COUNT:0] vld;
    mfm_pkg::st_t [mfm_pkg::CELL_COUNT:0] st;
    logic [319:0]                         t_full;
    logic [320:0]                         diff;
    logic [255:0]                         r_next;
    logic [255:0]                         r_reg;
    logic                                 m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        st_in   = '0;
        st_in.a = {s_a_limb3, s_a_limb2, s_a_limb1, s_a_limb0};
        case (mfm_pkg::kind_t'(s_kind))
            mfm_pkg::KIND_WORD:    st_in.b = {192'd0, s_b_limb0};
            mfm_pkg::KIND_TO_MONT: st_in.b = mfm_pkg::R_SQUARED;
            default:               st_in.b = {s_b_limb3, s_b_limb2, s_b_limb1, s_b_limb0};
        endcase
    end

    assign vld[0] = s_valid;
    assign st[0]  = st_in;

    for (genvar k = 0; k < mfm_pkg::CELL_COUNT; k++) begin : g_cell
        localparam int IT = k / mfm_pkg::STEPS_PER_ITER;
        localparam int PH = k % mfm_pkg::STEPS_PER_ITER;
        localparam mfm_pkg::op_t OP = mfm_pkg::op_t'(
                                      (PH < 4) ? mfm_pkg::OP_MAC_AB :
                                      (PH == 4) ? mfm_pkg::OP_MQINV :
                                      (PH == 5) ? mfm_pkg::OP_RED0 : mfm_pkg::OP_MAC_Q);
        localparam int JJ = (PH < 4) ? PH : PH - 5;

        mfm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .op        (OP),
            .iter      (2'(IT)),
            .idx       (2'(JJ)),
            .in_valid  (vld[k]),
            .in_st     (st[k]),
            .out_valid (vld[k+1]),
            .out_st    (st[k+1])
        );
    end

    // Final conditional subtraction of q.
    always_comb begin
        t_full = {st[mfm_pkg::CELL_COUNT].t[4], st[mfm_pkg::CELL_COUNT].t[3],
                  st[mfm_pkg::CELL_COUNT].t[2], st[mfm_pkg::CELL_COUNT].t[1],
                  st[mfm_pkg::CELL_COUNT].t[0]};
        diff   = {1'b0, t_full} - {65'd0, mfm_pkg::MOD_Q};
        r_next = diff[320] ? t_full[255:0] : diff[255:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld[mfm_pkg::CELL_COUNT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_r_limb0 = r_reg[63:0];
    assign m_r_limb1 = r_reg[127:64];
    assign m_r_limb2 = r_reg[191:128];
    assign m_r_limb3 = r_reg[255:192];

    `MFM_ASSERT_RST(a_stall_blocks_input, aclk, aresetn, (m_valid && !m_ready) |-> !s_ready)
    `MFM_ASSERT_CLK(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `MFM_ASSERT_RST(a_stall_holds_chain, aclk, aresetn, !en |=> $stable(vld[mfm_pkg::CELL_COUNT:1]))

endmodule
